// ===== hw/rtl/tpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch packet decoder package
// Shared types, codes and constants of the touch packet decoder.
// ----------------------------------------------------------------------------
package tpd_pkg;

	localparam int LEN_W = 6;
	localparam int PTS_W = 3;

	localparam logic [LEN_W-1:0] OFFSET_COUNT = 6'd4;
	localparam logic [LEN_W-1:0] OFFSET_MASK  = 6'd3;
	localparam logic [3:0]       COUNT_NONE   = 4'hF;
	localparam logic [7:0]       MASK_NONE    = 8'hFF;
	localparam logic [15:0]      COORD_EMPTY  = 16'hFFFF;
	localparam logic [7:0]       PRESS_ON     = 8'd200;
	localparam logic [7:0]       PRESS_OFF    = 8'd0;

	localparam logic [LEN_W-1:0] LEN_MIN     = 6'd8;
	localparam logic [LEN_W-1:0] LEN_RESET   = 6'd16;
	localparam logic [PTS_W-1:0] PTS_MIN     = 3'd1;
	localparam logic [PTS_W-1:0] PTS_RESET   = 3'd2;

	typedef enum logic [2:0] {
		CFG_PACKET_LENGTH = 3'd0,
		CFG_POINT_COUNT   = 3'd1,
		CFG_KEEP_XY_ORDER = 3'd2,
		CFG_FLIP_X        = 3'd3,
		CFG_FLIP_Y        = 3'd4,
		CFG_MULTI_MODE    = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_CONTACT = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_SYNC    = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_CNT,
		ST_RD_MASK,
		ST_CHECK,
		ST_PT_RD,
		ST_PT_EVAL,
		ST_PT_EMIT,
		ST_RELEASE,
		ST_SYNC
	} seq_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} byte_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  point_id;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [7:0]  pressure;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [PTS_W-1:0] pts;
		logic             keep_xy;
		logic             flip_x;
		logic             flip_y;
		logic             multi;
	} cfg_t;

endpackage

// ===== hw/rtl/tpd_stream_if.sv =====
// ----------------------------------------------------------------------------
// Touch packet decoder stream interface
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface tpd_stream_if #(
	parameter type T = logic [7:0]
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/tpd_store.sv =====
// ----------------------------------------------------------------------------
// Touch packet decoder packet store
// Byte-wide memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tpd_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/tpd_sequencer.sv =====
// ----------------------------------------------------------------------------
// Touch packet decoder sequencer
// Reads a stored packet back from memory and emits contact, release and sync
// results through an output register.
// ----------------------------------------------------------------------------
module tpd_sequencer #(
	parameter int MAX_X = 480,
	parameter int MAX_Y = 800
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tpd_pkg::cfg_t             cfg,
	input  logic                      start,
	output logic                      idle,
	output logic [tpd_pkg::LEN_W-1:0] rd_addr,
	input  logic [7:0]                rd_data,
	tpd_stream_if.source              result_out
);

	localparam logic [15:0] MAX_X_C = 16'(MAX_X);
	localparam logic [15:0] MAX_Y_C = 16'(MAX_Y);

	typedef struct packed {
		logic [15:0] value;
		logic        in_range;
		logic        empty;
	} axis_t;

	tpd_pkg::seq_state_t state_q, state_d;

	logic [3:0]  count_q;
	logic [7:0]  mask_q;
	logic [7:0]  prev_q;
	logic [2:0]  p_q;
	logic [2:0]  j_q;
	logic        inrange_q;
	logic [31:0] raw_q;
	logic [15:0] pos_x_q;
	logic [15:0] pos_y_q;
	logic        hit_q;
	logic        empty_q;

	logic             out_valid_q;
	tpd_pkg::result_t out_data_q;

	logic             can_load;
	logic             emit;
	logic             more;
	tpd_pkg::result_t emit_data;
	logic [tpd_pkg::LEN_W-1:0] pt_addr;
	logic [3:0]  count_byte;
	logic [7:0]  mask_byte;
	logic [15:0] x_raw;
	logic [15:0] y_raw;
	axis_t       ax;
	axis_t       ay;

	// An empty coordinate is never mirrored; a mirrored value below zero
	// clamps to zero and counts as out of range.
	function automatic axis_t axis_eval(logic [15:0] raw, logic [15:0] maxv, logic flip);
		axis_t r;
		r.empty    = (raw == tpd_pkg::COORD_EMPTY);
		r.in_range = (raw <= maxv);
		if (flip && !r.empty) begin
			r.value = r.in_range ? (maxv - raw) : 16'd0;
		end else begin
			r.value = raw;
		end
		return r;
	endfunction

	assign can_load   = !out_valid_q || result_out.ready;
	assign idle       = (state_q == tpd_pkg::ST_IDLE);
	assign pt_addr    = {1'b0, p_q, j_q[1:0]};
	assign count_byte = (rd_data[3:0] == tpd_pkg::COUNT_NONE) ? 4'd0 : rd_data[3:0];
	assign mask_byte  = (rd_data == tpd_pkg::MASK_NONE) ? 8'd0 : rd_data;
	assign more       = cfg.multi && (({1'b0, p_q} + 4'd1) < {1'b0, cfg.pts});
	assign x_raw      = cfg.keep_xy ? raw_q[31:16] : raw_q[15:0];
	assign y_raw      = cfg.keep_xy ? raw_q[15:0] : raw_q[31:16];
	assign ax         = axis_eval(x_raw, MAX_X_C, cfg.flip_x);
	assign ay         = axis_eval(y_raw, MAX_Y_C, cfg.flip_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d            = state_q;
		emit               = 1'b0;
		rd_addr            = '0;
		emit_data.kind     = tpd_pkg::KIND_CONTACT;
		emit_data.point_id = p_q;
		emit_data.pos_x    = pos_x_q;
		emit_data.pos_y    = pos_y_q;
		emit_data.pressure = tpd_pkg::PRESS_ON;
		emit_data.last     = 1'b0;
		case (state_q)
			tpd_pkg::ST_IDLE: begin
				if (start) begin
					state_d = tpd_pkg::ST_RD_CNT;
				end
			end
			tpd_pkg::ST_RD_CNT: begin
				rd_addr = cfg.len - tpd_pkg::OFFSET_COUNT;
				state_d = tpd_pkg::ST_RD_MASK;
			end
			tpd_pkg::ST_RD_MASK: begin
				rd_addr = cfg.len - tpd_pkg::OFFSET_MASK;
				state_d = tpd_pkg::ST_CHECK;
			end
			tpd_pkg::ST_CHECK: begin
				if (count_q > {1'b0, cfg.pts}) begin
					state_d = tpd_pkg::ST_IDLE;
				end else if (cfg.multi || count_q == 4'd1) begin
					state_d = tpd_pkg::ST_PT_RD;
				end else if (count_q == 4'd0) begin
					state_d = tpd_pkg::ST_RELEASE;
				end else begin
					state_d = tpd_pkg::ST_SYNC;
				end
			end
			tpd_pkg::ST_PT_RD: begin
				rd_addr = pt_addr;
				if (j_q == 3'd4) begin
					state_d = tpd_pkg::ST_PT_EVAL;
				end
			end
			tpd_pkg::ST_PT_EVAL: begin
				state_d = tpd_pkg::ST_PT_EMIT;
			end
			tpd_pkg::ST_PT_EMIT: begin
				if (!cfg.multi) begin
					emit = 1'b1;
				end else if (mask_q[p_q] && hit_q) begin
					emit = 1'b1;
				end else if (prev_q[p_q] && empty_q) begin
					emit = 1'b1;
					if (!mask_q[p_q]) begin
						emit_data.kind     = tpd_pkg::KIND_RELEASE;
						emit_data.pos_x    = 16'd0;
						emit_data.pos_y    = 16'd0;
						emit_data.pressure = tpd_pkg::PRESS_OFF;
					end
				end
				if (!emit || can_load) begin
					state_d = more ? tpd_pkg::ST_PT_RD : tpd_pkg::ST_SYNC;
				end
			end
			tpd_pkg::ST_RELEASE: begin
				emit               = 1'b1;
				emit_data.kind     = tpd_pkg::KIND_RELEASE;
				emit_data.point_id = 3'd0;
				emit_data.pos_x    = 16'd0;
				emit_data.pos_y    = 16'd0;
				emit_data.pressure = tpd_pkg::PRESS_OFF;
				if (can_load) begin
					state_d = tpd_pkg::ST_SYNC;
				end
			end
			tpd_pkg::ST_SYNC: begin
				emit               = 1'b1;
				emit_data.kind     = tpd_pkg::KIND_SYNC;
				emit_data.point_id = 3'd0;
				emit_data.pos_x    = 16'd0;
				emit_data.pos_y    = 16'd0;
				emit_data.pressure = tpd_pkg::PRESS_OFF;
				emit_data.last     = 1'b1;
				if (can_load) begin
					state_d = tpd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 8'd0;
			p_q         <= 3'd0;
			j_q         <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				tpd_pkg::ST_CHECK: begin
					p_q <= 3'd0;
					j_q <= 3'd0;
				end
				tpd_pkg::ST_PT_RD: begin
					j_q <= (j_q == 3'd4) ? 3'd0 : j_q + 3'd1;
				end
				tpd_pkg::ST_PT_EMIT: begin
					if ((!emit || can_load) && more) begin
						p_q <= p_q + 3'd1;
					end
				end
				tpd_pkg::ST_SYNC: begin
					if (can_load) begin
						prev_q <= mask_q;
					end
				end
				default: begin
				end
			endcase
			if (emit && can_load) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tpd_pkg::ST_RD_MASK: begin
				count_q <= count_byte;
			end
			tpd_pkg::ST_CHECK: begin
				mask_q <= mask_byte;
			end
			tpd_pkg::ST_PT_RD: begin
				inrange_q <= (pt_addr < cfg.len);
				if (j_q != 3'd0) begin
					raw_q <= {raw_q[23:0], inrange_q ? rd_data : 8'h00};
				end
			end
			tpd_pkg::ST_PT_EVAL: begin
				pos_x_q <= ax.value;
				pos_y_q <= ay.value;
				hit_q   <= ax.in_range && ay.in_range;
				empty_q <= ax.empty && ay.empty;
			end
			default: begin
			end
		endcase
		if (emit && can_load) begin
			out_data_q <= emit_data;
		end
	end

	assign result_out.valid   = out_valid_q;
	assign result_out.payload = out_data_q;

`ifndef SYNTH
	a_point_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpd_pkg::ST_PT_RD || state_q == tpd_pkg::ST_PT_EVAL ||
		 state_q == tpd_pkg::ST_PT_EMIT) |-> ({1'b0, p_q} < {1'b0, cfg.pts}))
		else $error("point index reached the point count");

	a_fetch_counter_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tpd_pkg::ST_PT_RD) |-> (j_q == 3'd0))
		else $error("byte fetch counter not cleared outside the fetch state");

	a_sync_updates_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpd_pkg::ST_SYNC && can_load) |=>
		(state_q == tpd_pkg::ST_IDLE && prev_q == $past(mask_q)))
		else $error("sync transaction did not update the previous mask");
`endif

endmodule

// ===== hw/rtl/touch_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// Touch packet decoder
// Collects event packet bytes into a memory and decodes each completed packet
// into contact, release and sync results.
//
// Channel     Dir  Payload                                     Transaction
// byte_in     in   data_byte                                   valid & ready
// result_out  out  kind, point_id, pos_x, pos_y, pressure, last valid & ready
// cfg         in   cfg_index, cfg_data                         cfg_wr_en
//
// A byte is taken every cycle while no packet is being decoded.
// After the last byte the decoder is busy while it reads the packet back
// through the registered read port of the packet memory and emits its
// results; a dropped packet gives no results.
// A stalled output holds the decoder and therefore the input.
// Reset clears control state only; the packet memory is not cleared.
// ----------------------------------------------------------------------------
module touch_packet_decoder #(
	parameter int MAX_PACKET = 32,
	parameter int MAX_POINTS = 5,
	parameter int MAX_X      = 480,
	parameter int MAX_Y      = 800
) (
	input  logic       clk,
	input  logic       arst_n,
	tpd_stream_if.sink   byte_in,
	tpd_stream_if.source result_out,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [5:0] cfg_data
);

	localparam int AW = $clog2(MAX_PACKET);
	localparam logic [6:0] MAX_LEN = 7'(MAX_PACKET);
	localparam logic [3:0] MAX_PTS = 4'(MAX_POINTS);

	logic [5:0] packet_length_q;
	logic [2:0] point_count_q;
	logic       keep_xy_order_q;
	logic       flip_x_q;
	logic       flip_y_q;
	logic       multi_mode_q;

	logic [5:0] byte_idx_q;

	tpd_pkg::cfg_t cfg;
	logic          accept;
	logic          last_byte;
	logic          seq_idle;
	logic [5:0]    rd_addr;
	logic [7:0]    rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_length_q <= tpd_pkg::LEN_RESET;
			point_count_q   <= tpd_pkg::PTS_RESET;
			keep_xy_order_q <= 1'b0;
			flip_x_q        <= 1'b0;
			flip_y_q        <= 1'b1;
			multi_mode_q    <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tpd_pkg::CFG_PACKET_LENGTH: packet_length_q <= cfg_data;
				tpd_pkg::CFG_POINT_COUNT:   point_count_q   <= cfg_data[2:0];
				tpd_pkg::CFG_KEEP_XY_ORDER: keep_xy_order_q <= cfg_data[0];
				tpd_pkg::CFG_FLIP_X:        flip_x_q        <= cfg_data[0];
				tpd_pkg::CFG_FLIP_Y:        flip_y_q        <= cfg_data[0];
				tpd_pkg::CFG_MULTI_MODE:    multi_mode_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (packet_length_q < tpd_pkg::LEN_MIN) begin
			cfg.len = tpd_pkg::LEN_MIN;
		end else if ({1'b0, packet_length_q} > MAX_LEN) begin
			cfg.len = MAX_LEN[5:0];
		end else begin
			cfg.len = packet_length_q;
		end
		if (point_count_q < tpd_pkg::PTS_MIN) begin
			cfg.pts = tpd_pkg::PTS_MIN;
		end else if ({1'b0, point_count_q} > MAX_PTS) begin
			cfg.pts = MAX_PTS[2:0];
		end else begin
			cfg.pts = point_count_q;
		end
		cfg.keep_xy = keep_xy_order_q;
		cfg.flip_x  = flip_x_q;
		cfg.flip_y  = flip_y_q;
		cfg.multi   = multi_mode_q;
	end

	assign byte_in.ready = seq_idle;
	assign accept        = byte_in.valid && seq_idle;
	assign last_byte     = (({1'b0, byte_idx_q} + 7'd1) >= {1'b0, cfg.len});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= 6'd0;
		end else if (accept) begin
			byte_idx_q <= last_byte ? 6'd0 : byte_idx_q + 6'd1;
		end
	end

	tpd_store #(
		.DEPTH (MAX_PACKET),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && ({1'b0, byte_idx_q} < MAX_LEN)),
		.wr_addr (byte_idx_q[AW-1:0]),
		.wr_data (byte_in.payload.data_byte),
		.rd_addr (rd_addr[AW-1:0]),
		.rd_data (rd_data)
	);

	tpd_sequencer #(
		.MAX_X (MAX_X),
		.MAX_Y (MAX_Y)
	) u_sequencer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.start      (accept && last_byte),
		.idle       (seq_idle),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.result_out (result_out)
	);

`ifndef SYNTH
	a_index_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, byte_idx_q} < MAX_LEN))
		else $error("byte index left the packet store");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Touch packet decoder testbench
// Streams event packet bytes into the decoder under random idling and stalls,
// predicts the contact, release and sync reports of every packet, and checks
// each report against the oldest expected one across several register setups.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PKT       = 32;
	localparam int MAX_PTS       = 5;
	localparam int X_MAX         = 480;
	localparam int Y_MAX         = 800;
	localparam int EMPTY_XY      = int'(tpd_pkg::COORD_EMPTY);
	localparam int SETTLE_CYCLES = 4 + 7 * MAX_PTS + 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_PCT      = 36;

	// Four hand-built packets: contact, contact at the empty marker, release, dropped.
	localparam logic [255:0] DIRECTED =
		256'h0010_0020_0101_AA55_FFFF_FFFF_0101_0000_FFFF_FFFF_0F00_0000_1234_5678_09FF_0000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [2:0] cfg_index = tpd_pkg::CFG_PACKET_LENGTH;
	logic [5:0] cfg_data = '0;

	tpd_stream_if #(.T(tpd_pkg::byte_item_t)) byte_if ();
	tpd_stream_if #(.T(tpd_pkg::result_t))    res_if ();

	touch_packet_decoder #(
		.MAX_PACKET(MAX_PKT),
		.MAX_POINTS(MAX_PTS),
		.MAX_X(X_MAX),
		.MAX_Y(Y_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_if),
		.result_out(res_if),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [7:0]       pending_bytes [$];
	tpd_pkg::result_t expected_reports [$];
	int               err_cnt = 0;
	bit               tx_idle_en = 1'b1;
	bit               rx_idle_en = 1'b1;
	bit               hold_req = 1'b0;
	bit               hold_done = 1'b0;
	int unsigned      hold_left = 0;

	logic [7:0]  pkt_mem [MAX_PKT];
	int unsigned byte_pos = 0;
	logic [7:0]  prev_mask = '0;
	logic [5:0]  cfg_len = tpd_pkg::LEN_RESET;
	logic [2:0]  cfg_pts = tpd_pkg::PTS_RESET;
	logic        cfg_keep = 1'b0;
	logic        cfg_fx = 1'b0;
	logic        cfg_fy = 1'b1;
	logic        cfg_multi = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned eff_len();
		if (cfg_len < tpd_pkg::LEN_MIN) return 32'(tpd_pkg::LEN_MIN);
		if (cfg_len > MAX_PKT) return MAX_PKT;
		return 32'(cfg_len);
	endfunction

	function automatic int unsigned eff_pts();
		if (cfg_pts < tpd_pkg::PTS_MIN) return 32'(tpd_pkg::PTS_MIN);
		if (cfg_pts > MAX_PTS) return MAX_PTS;
		return 32'(cfg_pts);
	endfunction

	function automatic int unsigned store_at(int unsigned idx, int unsigned len);
		return (idx < len) ? 32'(pkt_mem[idx]) : 0;
	endfunction

	function automatic void point_xy(int unsigned p, int unsigned len, output int x,
			output int y);
		int unsigned b;
		int t;
		b = 4 * p;
		x = int'((store_at(b, len) << 8) | store_at(b + 1, len));
		y = int'((store_at(b + 2, len) << 8) | store_at(b + 3, len));
		if (!cfg_keep) begin
			t = x;
			x = y;
			y = t;
		end
		if (cfg_fx && x != EMPTY_XY) x = X_MAX - x;
		if (cfg_fy && y != EMPTY_XY) y = Y_MAX - y;
	endfunction

	function automatic void push_report(tpd_pkg::kind_t k, int id, int x, int y);
		tpd_pkg::result_t r;
		r.kind = k;
		r.point_id = id[2:0];
		r.pos_x = x[15:0];
		r.pos_y = y[15:0];
		r.pressure = (k == tpd_pkg::KIND_CONTACT) ? tpd_pkg::PRESS_ON : tpd_pkg::PRESS_OFF;
		r.last = (k == tpd_pkg::KIND_SYNC);
		expected_reports.push_back(r);
	endfunction

	function automatic void predict_packet_byte(logic [7:0] b);
		int unsigned len, pts, cnt;
		logic [7:0] msk;
		int x, y;
		len = eff_len();
		pts = eff_pts();
		if (byte_pos < MAX_PKT) pkt_mem[byte_pos] = b;
		if (byte_pos + 1 < len) begin
			byte_pos = (byte_pos + 1) & 32'h3F;
			return;
		end
		byte_pos = 0;
		cnt = store_at(len - tpd_pkg::OFFSET_COUNT, len) & 32'hF;
		if (cnt == tpd_pkg::COUNT_NONE) cnt = 0;
		if (cnt > pts) return;
		msk = 8'(store_at(len - tpd_pkg::OFFSET_MASK, len));
		if (msk == tpd_pkg::MASK_NONE) msk = '0;
		if (cfg_multi) begin
			for (int i = 0; i < pts; i++) begin
				point_xy(i, len, x, y);
				if (msk[i] && x >= 0 && x <= X_MAX && y >= 0 && y <= Y_MAX) begin
					push_report(tpd_pkg::KIND_CONTACT, i, x, y);
				end else if (prev_mask[i] && x == EMPTY_XY && y == EMPTY_XY) begin
					if (msk[i]) push_report(tpd_pkg::KIND_CONTACT, i, x, y);
					else push_report(tpd_pkg::KIND_RELEASE, i, 0, 0);
				end
			end
		end else if (cnt == 1) begin
			point_xy(0, len, x, y);
			if (x < 0) x = 0;
			if (y < 0) y = 0;
			push_report(tpd_pkg::KIND_CONTACT, 0, x, y);
		end else if (cnt == 0) begin
			push_report(tpd_pkg::KIND_RELEASE, 0, 0, 0);
		end
		push_report(tpd_pkg::KIND_SYNC, 0, 0, 0);
		prev_mask = msk;
	endfunction

	function automatic string fmt_result(tpd_pkg::result_t r);
		return $sformatf("kind %0d id %0d x %0d y %0d pressure %0d last %0d",
			r.kind, r.point_id, r.pos_x, r.pos_y, r.pressure, r.last);
	endfunction

	function automatic void note_error(string msg);
		if (err_cnt < 10) $display("ERROR at %0t: %s", $realtime, msg);
		err_cnt++;
	endfunction

	always @(posedge clk) begin
		logic offer;
		if (!arst_n) begin
			byte_if.valid <= 1'b0;
			byte_if.payload <= '0;
		end else begin
			if (byte_if.valid && byte_if.ready) predict_packet_byte(byte_if.payload.data_byte);
			if (!byte_if.valid || byte_if.ready) begin
				offer = pending_bytes.size() != 0 &&
					(!tx_idle_en || $urandom_range(99) >= IDLE_PCT);
				if (offer) byte_if.payload.data_byte <= pending_bytes.pop_front();
				byte_if.valid <= offer;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		tpd_pkg::result_t want, got;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got = res_if.payload;
				if (expected_reports.size() == 0) begin
					note_error({"report with none expected: ", fmt_result(got)});
				end else begin
					want = expected_reports.pop_front();
					if (want.kind !== got.kind || want.point_id !== got.point_id ||
							want.pos_x !== got.pos_x || want.pos_y !== got.pos_y ||
							want.pressure !== got.pressure || want.last !== got.last)
						note_error({"expected ", fmt_result(want), ", got ", fmt_result(got)});
				end
			end
			res_if.ready <= (hold_left == 0) && (!rx_idle_en || $urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic write_reg(input tpd_pkg::cfg_idx_t idx, input logic [5:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			tpd_pkg::CFG_PACKET_LENGTH: cfg_len = val;
			tpd_pkg::CFG_POINT_COUNT:   cfg_pts = val[2:0];
			tpd_pkg::CFG_KEEP_XY_ORDER: cfg_keep = val[0];
			tpd_pkg::CFG_FLIP_X:        cfg_fx = val[0];
			tpd_pkg::CFG_FLIP_Y:        cfg_fy = val[0];
			tpd_pkg::CFG_MULTI_MODE:    cfg_multi = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_config(input logic [5:0] len, input logic [2:0] pts, input bit keep,
			input bit fx, input bit fy, input bit multi);
		write_reg(tpd_pkg::CFG_PACKET_LENGTH, len);
		write_reg(tpd_pkg::CFG_POINT_COUNT, {3'd0, pts});
		write_reg(tpd_pkg::CFG_KEEP_XY_ORDER, {5'd0, keep});
		write_reg(tpd_pkg::CFG_FLIP_X, {5'd0, fx});
		write_reg(tpd_pkg::CFG_FLIP_Y, {5'd0, fy});
		write_reg(tpd_pkg::CFG_MULTI_MODE, {5'd0, multi});
	endtask

	task automatic drain();
		while (pending_bytes.size() != 0 || byte_if.valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'(X_MAX);
			2: return 16'(Y_MAX);
			3: return 16'(X_MAX + 1);
			4: return 16'(Y_MAX + 1);
			5: return 16'($urandom_range(Y_MAX));
			6: return tpd_pkg::COORD_EMPTY;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	function automatic void queue_packet();
		logic [7:0] pkt [MAX_PKT];
		int unsigned len, pts;
		logic [15:0] cx, cy;
		logic [3:0] lo;
		logic [7:0] msk;
		len = eff_len();
		pts = eff_pts();
		foreach (pkt[i]) pkt[i] = 8'($urandom_range(255));
		if ($urandom_range(99) >= 12) begin
			for (int i = 0; i < pts; i++) begin
				if (4 * i + 3 < len - 4) begin
					if ($urandom_range(3) == 0) begin
						cx = tpd_pkg::COORD_EMPTY;
						cy = tpd_pkg::COORD_EMPTY;
					end else begin
						cx = pick_coord();
						cy = pick_coord();
					end
					pkt[4 * i] = cx[15:8];
					pkt[4 * i + 1] = cx[7:0];
					pkt[4 * i + 2] = cy[15:8];
					pkt[4 * i + 3] = cy[7:0];
				end
			end
			case ($urandom_range(9))
				0, 1, 2, 3, 4: lo = 4'($urandom_range(pts));
				5: lo = tpd_pkg::COUNT_NONE;
				6: lo = 4'(pts + 1);
				7: lo = 4'($urandom_range(15));
				default: lo = 4'd1;
			endcase
			case ($urandom_range(7))
				0, 1, 2, 3, 4: msk = 8'($urandom_range((1 << pts) - 1));
				5: msk = tpd_pkg::MASK_NONE;
				6: msk = 8'($urandom_range(255));
				default: msk = '0;
			endcase
			pkt[len - tpd_pkg::OFFSET_COUNT] = {4'($urandom_range(15)), lo};
			pkt[len - tpd_pkg::OFFSET_MASK] = msk;
		end
		for (int i = 0; i < len; i++) pending_bytes.push_back(pkt[i]);
	endfunction

	task automatic run_phase(input logic [5:0] len, input logic [2:0] pts, input bit keep,
			input bit fx, input bit fy, input bit multi, input int packets, input bit idling,
			input int tail, input bit stall);
		set_config(len, pts, keep, fx, fy, multi);
		@(negedge clk);
		tx_idle_en = idling;
		rx_idle_en = idling;
		hold_req = stall;
		repeat (packets) queue_packet();
		repeat (tail) pending_bytes.push_back(8'($urandom_range(255)));
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		set_config(6'd0, 3'd7, 1'b1, 1'b0, 1'b0, 1'b1);
		@(negedge clk);
		for (int i = 0; i < 32; i++) pending_bytes.push_back(DIRECTED[255 - 8 * i -: 8]);
		drain();

		run_phase(6'd16, 3'd2, 1'b0, 1'b0, 1'b1, 1'b1, 4, 1'b1, 0, 1'b0);
		run_phase(6'd63, 3'd0, 1'b0, 1'b1, 1'b1, 1'b1, 2, 1'b1, 0, 1'b0);
		run_phase(6'd8, 3'd5, 1'b1, 1'b1, 1'b0, 1'b0, 8, 1'b1, 0, 1'b0);
		run_phase(6'd12, 3'd5, 1'b1, 1'b0, 1'b1, 1'b1, 6, 1'b0, 0, 1'b0);
		run_phase(6'd32, 3'd7, 1'b0, 1'b1, 1'b1, 1'b0, 2, 1'b1, 0, 1'b0);
		run_phase(6'd20, 3'd3, 1'b1, 1'b1, 1'b1, 1'b1, 4, 1'b1, 0, 1'b1);
		// The next phase leaves a packet half sent, so the following length change
		// lands in the middle of a packet.
		run_phase(6'd10, 3'd4, 1'b0, 1'b0, 1'b0, 1'b1, 6, 1'b1, 5, 1'b0);
		run_phase(6'd8, 3'd1, 1'b1, 1'b0, 1'b0, 1'b0, 6, 1'b1, 0, 1'b0);

		if (err_cnt == 0) begin
			$display("touch_packet_decoder regression: pass");
		end else begin
			$display("touch_packet_decoder regression: fail");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("touch_packet_decoder regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_stream_if.sv
hw/rtl/tpd_store.sv
hw/rtl/tpd_sequencer.sv
hw/rtl/touch_packet_decoder.sv
sim/tb_top.sv
